>>> hdl/mbfe_pkg.sv
// Shared types, constants and register map of the monochrome bitmap expander.
`default_nettype none
package mbfe_pkg;

  localparam int SW_BITS  = 13;
  localparam int BPP_BITS = 4;
  localparam int LL_BITS  = 16;
  localparam int OFF_BITS = 32;
  localparam int PIX_BITS = 8;

  localparam int DEF_MAX_SCREEN_WIDTH = 4096;
  localparam int DEF_ROW_COUNT_BITS   = 16;

  localparam logic [SW_BITS-1:0]  SW_RESET  = 13'd512;
  localparam logic [BPP_BITS-1:0] BPP_RESET = 4'd4;
  localparam logic [LL_BITS-1:0]  LL_RESET  = 16'd2048;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REG_PIX_PER_ROW     = 2'd0;
  localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE      = 2'd2;

  localparam logic [2:0] PIX_LAST = 3'd7;

  localparam logic [7:0] INT_SET   = 8'd0;
  localparam logic [7:0] INT_CLEAR = 8'd255;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [SW_BITS-1:0]  pix_per_row;
    logic [BPP_BITS-1:0] bytes_per_pixel;
    logic [LL_BITS-1:0]  row_stride;
  } cfg_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] data_byte;
    logic                first_byte;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage
`default_nettype wire

>>> hdl/mbfe_cfg_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module mbfe_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mbfe_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [mbfe_pkg::DATA_BITS-1:0] pwdata,
  output logic      [mbfe_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready,
  output mbfe_pkg::cfg_t                      cfg
);
  import mbfe_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PIX_PER_ROW:     cfg_nxt.pix_per_row     = pwdata[SW_BITS-1:0];
        REG_BYTES_PER_PIXEL: cfg_nxt.bytes_per_pixel = pwdata[BPP_BITS-1:0];
        REG_ROW_STRIDE:      cfg_nxt.row_stride      = pwdata[LL_BITS-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PIX_PER_ROW:     prdata = DATA_BITS'(cfg_r.pix_per_row);
      REG_BYTES_PER_PIXEL: prdata = DATA_BITS'(cfg_r.bytes_per_pixel);
      REG_ROW_STRIDE:      prdata = DATA_BITS'(cfg_r.row_stride);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pix_per_row     <= SW_RESET;
      cfg_r.bytes_per_pixel <= BPP_RESET;
      cfg_r.row_stride      <= LL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mbfe_front.sv
// Input side: accepts bitmap bytes into a short queue toward the pixel engine.
`default_nettype none
module mbfe_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mbfe_pkg::PIX_BITS-1:0] in_data_byte,
  input  wire logic                          in_first_byte,
  output mbfe_pkg::q_head_t                  q_head,
  input  wire logic                          q_pop
);
  import mbfe_pkg::*;

  q_entry_t                mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr_r;
  logic [Q_PTR_BITS-1:0]   wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0]   rd_ptr_r;
  logic [Q_PTR_BITS-1:0]   rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0]   count_r;
  logic [Q_CNT_BITS-1:0]   count_nxt;
  logic                    push;
  logic                    pop;

  assign in_ready           = (count_r != Q_CNT_BITS'(Q_DEPTH));
  assign push               = in_valid && in_ready;
  assign q_head.valid       = (count_r != '0);
  assign q_head.entry       = mem_r[rd_ptr_r];
  assign pop                = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_BITS'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].data_byte  <= in_data_byte;
      mem_r[wr_ptr_r].first_byte <= in_first_byte;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mbfe_back.sv
// Pixel engine: walks each byte into eight pixel writes and forms their offsets.
`default_nettype none
module mbfe_back #(
  parameter int MAX_SCREEN_WIDTH = mbfe_pkg::DEF_MAX_SCREEN_WIDTH,
  parameter int ROW_COUNT_BITS   = mbfe_pkg::DEF_ROW_COUNT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mbfe_pkg::cfg_t                cfg,
  input  wire mbfe_pkg::q_head_t             q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mbfe_pkg::OFF_BITS-1:0]      out_byte_offset,
  output logic [mbfe_pkg::PIX_BITS-1:0]      out_intensity,
  output logic                               out_last_pixel
);
  import mbfe_pkg::*;

  localparam int COL_BITS = $clog2(MAX_SCREEN_WIDTH);
  localparam int WID_BITS = (COL_BITS + 1 > SW_BITS) ? COL_BITS + 1 : SW_BITS;
  localparam int CP_BITS  = COL_BITS + BPP_BITS;
  localparam int RP_BITS  = ROW_COUNT_BITS + LL_BITS;

  logic                      a_busy_r, a_busy_nxt;
  logic [PIX_BITS-1:0]       a_data_r, a_data_nxt;
  logic [2:0]                a_k_r, a_k_nxt;
  logic [COL_BITS-1:0]       col_r, col_nxt;
  logic [ROW_COUNT_BITS-1:0] row_r, row_nxt;

  logic                      b_valid_r, b_valid_nxt;
  logic [CP_BITS-1:0]        b_col_prod_r;
  logic [OFF_BITS-1:0]       b_row_prod_r;
  logic [PIX_BITS-1:0]       b_int_r;
  logic                      b_last_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [OFF_BITS-1:0]       out_off_r;
  logic [PIX_BITS-1:0]       out_int_r;
  logic                      out_last_r;

  logic                      ready_c, ready_b, a_fire, a_done;
  logic [WID_BITS-1:0]       width_eff, sw_ext, col_inc;
  logic                      wrap;
  logic [CP_BITS-1:0]        col_prod;
  logic [RP_BITS-1:0]        row_prod;

  assign ready_c = !out_valid_r || out_ready;
  assign ready_b = !b_valid_r || ready_c;
  assign a_fire  = a_busy_r && ready_b;
  assign a_done  = a_fire && (a_k_r == PIX_LAST);
  assign q_pop   = q_head.valid && (!a_busy_r || a_done);

  assign sw_ext  = WID_BITS'(cfg.pix_per_row);
  assign col_inc = WID_BITS'(col_r) + WID_BITS'(1);
  assign wrap    = (col_inc >= width_eff);

  assign col_prod = CP_BITS'(col_r) * CP_BITS'(cfg.bytes_per_pixel);
  assign row_prod = RP_BITS'(row_r) * RP_BITS'(cfg.row_stride);

  always_comb begin
    if (sw_ext == '0) begin
      width_eff = WID_BITS'(1);
    end else if (sw_ext > WID_BITS'(MAX_SCREEN_WIDTH)) begin
      width_eff = WID_BITS'(MAX_SCREEN_WIDTH);
    end else begin
      width_eff = sw_ext;
    end
  end

  always_comb begin
    a_busy_nxt = a_busy_r;
    a_data_nxt = a_data_r;
    a_k_nxt    = a_k_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (a_fire) begin
      a_data_nxt = {a_data_r[PIX_BITS-2:0], 1'b0};
      a_k_nxt    = a_k_r + 3'd1;
      if (wrap) begin
        col_nxt = '0;
        if (row_r != '1) begin
          row_nxt = row_r + ROW_COUNT_BITS'(1);
        end
      end else begin
        col_nxt = col_inc[COL_BITS-1:0];
      end
      if (a_done) begin
        a_busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      a_busy_nxt = 1'b1;
      a_data_nxt = q_head.entry.data_byte;
      a_k_nxt    = '0;
      if (q_head.entry.first_byte) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  assign b_valid_nxt   = ready_b ? a_fire : b_valid_r;
  assign out_valid_nxt = ready_c ? b_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_busy_r    <= 1'b0;
      a_k_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_busy_r    <= a_busy_nxt;
      a_k_r       <= a_k_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_data_r <= a_data_nxt;
    if (a_fire) begin
      b_col_prod_r <= col_prod;
      b_row_prod_r <= OFF_BITS'(row_prod);
      b_int_r      <= a_data_r[PIX_BITS-1] ? INT_SET : INT_CLEAR;
      b_last_r     <= (a_k_r == PIX_LAST);
    end
    if (ready_c && b_valid_r) begin
      out_off_r  <= OFF_BITS'(b_col_prod_r) + b_row_prod_r;
      out_int_r  <= b_int_r;
      out_last_r <= b_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_offset = out_off_r;
  assign out_intensity   = out_int_r;
  assign out_last_pixel  = out_last_r;

endmodule
`default_nettype wire

>>> hdl/mono_bitmap_to_framebuffer_expander.sv
// Top level of the monochrome bitmap to framebuffer pixel expander.
// The input channel (in_valid/in_ready) takes one bitmap byte per item, most
// significant bit leftmost, with in_first_byte marking the start of a buffer.
// Each byte leaves on the output channel (out_valid/out_ready) as eight pixel
// items carrying the framebuffer byte offset, the colour intensity and a flag
// on the eighth pixel. Screen width, bytes per pixel and line length are set
// through the APB-style port; the user must write them only while the block is
// idle, as the block itself does not enforce this. The first pixel of a byte
// passes through the queue, the pixel engine, the multiply stage and the output
// register; the engine gives one pixel per cycle while the output is not stalled.
// A two-entry queue holds bytes ahead of the pixel engine, and the offset
// pipeline has a multiply stage and an output register.
// When the receiver stalls, the output register holds its item, the pipeline
// fills, and once the queue is full in_ready drops.
// Reset clears the queue, the pipeline and the column and row counters, and
// returns the registers to their default values.
`default_nettype none
module mono_bitmap_to_framebuffer_expander #(
  parameter int MAX_SCREEN_WIDTH = mbfe_pkg::DEF_MAX_SCREEN_WIDTH,
  parameter int ROW_COUNT_BITS   = mbfe_pkg::DEF_ROW_COUNT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mbfe_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [mbfe_pkg::DATA_BITS-1:0] pwdata,
  output logic      [mbfe_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mbfe_pkg::PIX_BITS-1:0]  in_data_byte,
  input  wire logic                           in_first_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [mbfe_pkg::OFF_BITS-1:0]  out_byte_offset,
  output logic      [mbfe_pkg::PIX_BITS-1:0]  out_intensity,
  output logic                                out_last_pixel
);
  import mbfe_pkg::*;

  cfg_t    cfg;
  q_head_t q_head;
  logic    q_pop;

  mbfe_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbfe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  mbfe_back #(
    .MAX_SCREEN_WIDTH (MAX_SCREEN_WIDTH),
    .ROW_COUNT_BITS   (ROW_COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_offset (out_byte_offset),
    .out_intensity   (out_intensity),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the monochrome bitmap to framebuffer pixel expander.
`timescale 1ns / 100ps
module testbench;
  import mbfe_pkg::*;

  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          SETTLE_CYCLES   = 6;
  localparam int          END_CYCLES      = 16;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          SOAK_BYTES      = 16;
  localparam int          RAND_PHASES     = 6;
  localparam int          ITEMS_PER_PHASE = 14;
  localparam int unsigned ROW_MAX         = (1 << DEF_ROW_COUNT_BITS) - 1;
  localparam logic [1:0]  REG_UNUSED      = 2'd3;

  typedef struct packed {
    logic [OFF_BITS-1:0] offset;
    logic [PIX_BITS-1:0] intensity;
    logic                last_pixel;
  } pixel_t;

  typedef pixel_t [7:0] pixel_set_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic [7:0]  data;
    logic        first;
    logic        typed;
    logic [31:0] base;
    logic [31:0] step;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_BITS-1:0]  in_data_byte = '0;
  logic                 in_first_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OFF_BITS-1:0]  out_byte_offset;
  logic [PIX_BITS-1:0]  out_intensity;
  logic                 out_last_pixel;

  logic [SW_BITS-1:0]  cfg_width = SW_RESET;
  logic [BPP_BITS-1:0] cfg_bpp   = BPP_RESET;
  logic [LL_BITS-1:0]  cfg_line  = LL_RESET;
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;

  pixel_t    pending_pixels[$];
  stim_row_t directed_rows[$];
  int        n_errors = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;

  mono_bitmap_to_framebuffer_expander DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_first_byte   (in_first_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_offset (out_byte_offset),
    .out_intensity   (out_intensity),
    .out_last_pixel  (out_last_pixel)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pixel_set_t expand_byte(input logic [7:0] d, input logic f);
    pixel_set_t  px;
    int unsigned wrap_at;
    wrap_at = cfg_width;
    if (wrap_at == 0) wrap_at = 1;
    if (wrap_at > DEF_MAX_SCREEN_WIDTH) wrap_at = DEF_MAX_SCREEN_WIDTH;
    if (f) begin
      col_pos = 0;
      row_pos = 0;
    end
    for (int k = 0; k < 8; k++) begin
      px[k].offset     = col_pos * cfg_bpp + row_pos * cfg_line;
      px[k].intensity  = d[7-k] ? INT_SET : INT_CLEAR;
      px[k].last_pixel = (3'(k) == PIX_LAST);
      col_pos++;
      if (col_pos >= wrap_at) begin
        col_pos = 0;
        if (row_pos < ROW_MAX) row_pos++;
      end
    end
    return px;
  endfunction

  function automatic void add_byte(input logic [7:0] d, input logic f, input logic typed,
                                   input logic [31:0] base, input logic [31:0] step);
    stim_row_t row;
    row = '{kind: ROW_BYTE, reg_idx: '0, value: '0, data: d, first: f, typed: typed,
            base: base, step: step};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] v);
    stim_row_t row;
    row = '{kind: ROW_CFG, reg_idx: idx, value: v, data: '0, first: 1'b0, typed: 1'b0,
            base: '0, step: '0};
    directed_rows.push_back(row);
  endfunction

  task automatic push_byte(input logic [7:0] d, input logic f, input logic typed,
                           input logic [31:0] base, input logic [31:0] step);
    pixel_set_t px;
    int         gap;
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_first_byte <= f;
    do @(posedge clk); while (!in_ready);
    px = expand_byte(d, f);
    for (int k = 0; k < 8; k++) begin
      if (typed) px[k].offset = base + 32'(k) * step;
      pending_pixels.push_back(px[k]);
    end
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PIX_PER_ROW: begin
        cfg_width = v[SW_BITS-1:0];
        want      = 32'(cfg_width);
      end
      REG_BYTES_PER_PIXEL: begin
        cfg_bpp = v[BPP_BITS-1:0];
        want    = 32'(cfg_bpp);
      end
      REG_ROW_STRIDE: begin
        cfg_line = v[LL_BITS-1:0];
        want     = 32'(cfg_line);
      end
      default: want = '0;
    endcase
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_checker
    pixel_t want;
    int     stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel item: byte_offset %0d", out_byte_offset);
          n_errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_byte_offset !== want.offset) begin
            $error("byte_offset: expected %0d, got %0d", want.offset, out_byte_offset);
            n_errors++;
          end
          if (out_intensity !== want.intensity) begin
            $error("intensity: expected %0d, got %0d", want.intensity, out_intensity);
            n_errors++;
          end
          if (out_last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", want.last_pixel, out_last_pixel);
            n_errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rst_n) begin
        stall_left = draw_gap();
      end
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   row;
    int          pause_at;
    logic [31:0] v;
    logic        f;

    // Defaults after reset: width 512, 4 bytes per pixel, 2048-byte stride.
    add_byte(8'hFF, 1'b1, 1'b1, 32'd0, 32'd4);
    add_byte(8'h00, 1'b0, 1'b1, 32'd32, 32'd4);
    add_byte(8'hAA, 1'b1, 1'b1, 32'd0, 32'd4);
    add_byte(8'h55, 1'b0, 1'b1, 32'd32, 32'd4);
    add_byte(8'hF0, 1'b0, 1'b0, '0, '0);
    add_byte(8'h0F, 1'b0, 1'b0, '0, '0);
    add_byte(8'hCC, 1'b0, 1'b0, '0, '0);
    add_byte(8'h33, 1'b0, 1'b0, '0, '0);
    add_cfg(REG_PIX_PER_ROW, 32'd8);
    add_byte(8'h81, 1'b1, 1'b1, 32'd0, 32'd4);
    add_byte(8'h7E, 1'b0, 1'b1, 32'd2048, 32'd4);
    // A zero width behaves as one pixel per row.
    add_cfg(REG_PIX_PER_ROW, 32'd0);
    add_byte(8'h3C, 1'b1, 1'b1, 32'd0, 32'd2048);
    add_cfg(REG_PIX_PER_ROW, 32'hFFFF_FFFF);
    add_cfg(REG_BYTES_PER_PIXEL, 32'hFFFF_FFFF);
    add_cfg(REG_ROW_STRIDE, 32'hFFFF_FFFF);
    add_byte(8'h12, 1'b1, 1'b0, '0, '0);
    add_byte(8'h34, 1'b0, 1'b0, '0, '0);
    add_cfg(REG_BYTES_PER_PIXEL, 32'd0);
    add_byte(8'h56, 1'b1, 1'b1, 32'd0, 32'd0);
    add_cfg(REG_BYTES_PER_PIXEL, 32'd3);
    add_cfg(REG_ROW_STRIDE, 32'd0);
    add_byte(8'h78, 1'b1, 1'b1, 32'd0, 32'd3);
    add_cfg(REG_PIX_PER_ROW, 32'd12);
    add_cfg(REG_BYTES_PER_PIXEL, 32'd8);
    add_cfg(REG_ROW_STRIDE, 32'd1000);
    add_byte(8'h9A, 1'b1, 1'b1, 32'd0, 32'd8);
    add_byte(8'hBC, 1'b0, 1'b0, '0, '0);
    // The width drops below the current column in the middle of a buffer.
    add_cfg(REG_PIX_PER_ROW, 32'd3);
    add_byte(8'hDE, 1'b0, 1'b0, '0, '0);
    add_byte(8'hEF, 1'b0, 1'b0, '0, '0);
    add_cfg(REG_UNUSED, 32'd1);
    add_byte(8'h01, 1'b0, 1'b0, '0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_drain();
        reg_write(row.reg_idx, row.value);
      end else begin
        push_byte(row.data, row.first, row.typed, row.base, row.step);
      end
    end

    // One pixel per row at full rate.
    wait_drain();
    idle_on = 1'b0;
    reg_write(REG_PIX_PER_ROW, 32'd1);
    reg_write(REG_BYTES_PER_PIXEL, 32'd8);
    reg_write(REG_ROW_STRIDE, 32'd1);
    for (int n = 0; n < SOAK_BYTES; n++) begin
      push_byte(8'($urandom_range(0, 255)), (n == 0), 1'b0, '0, '0);
    end
    idle_on = 1'b1;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drain();
      v = $urandom();
      case ($urandom_range(0, 5))
        0: v[SW_BITS-1:0] = 13'd1;
        1: v[SW_BITS-1:0] = 13'd4096;
        2: v[SW_BITS-1:0] = 13'($urandom_range(1, 16));
        3: v[SW_BITS-1:0] = 13'($urandom_range(17, 600));
        4: v[SW_BITS-1:0] = 13'($urandom_range(0, 8191));
        default: v[SW_BITS-1:0] = 13'd8;
      endcase
      reg_write(REG_PIX_PER_ROW, v);
      v = $urandom();
      if ($urandom_range(0, 99) < 80) v[BPP_BITS-1:0] = 4'($urandom_range(3, 8));
      reg_write(REG_BYTES_PER_PIXEL, v);
      v = $urandom();
      case ($urandom_range(0, 3))
        0: v[LL_BITS-1:0] = 16'd65535;
        1: v[LL_BITS-1:0] = 16'd1;
        default: ;
      endcase
      reg_write(REG_ROW_STRIDE, v);
      if (ph == 1) pause_at = ITEMS_PER_PHASE - 1;
      else pause_at = $urandom_range(1, ITEMS_PER_PHASE - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 2) hold_req = 1'b1;
        if (n == pause_at) wait_drain();
        if (n == 0) f = 1'($urandom_range(0, 1));
        else f = ($urandom_range(0, 7) == 0);
        push_byte(8'($urandom_range(0, 255)), f, 1'b0, '0, '0);
      end
    end

    wait_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d pixel items never arrived", pending_pixels.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
